FILE: hw/rtl/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg: shared types and constants
// Entry layout of the detection store and default parameter values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cnms_pkg;

  localparam int unsigned MaxDetsDefault    = 64;
  localparam int unsigned CoordBitsDefault  = 16;
  localparam logic [15:0] ThresholdReset    = 16'd19661;

  // The sup bit marks an entry suppressed during the pass; insertion writes it low.
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
    logic [9:0]  cls;
    logic [31:0] area;
    logic        sup;
  } cnms_entry_t;

  function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
    span16 = (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cnms_det_if.sv
// ----------------------------------------------------------------------------
// cnms_det_if: detection input channel
// Valid/ready channel carrying one detection per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cnms_det_if;
  logic        valid;
  logic        ready;
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] right;
  logic [15:0] bottom;
  logic [15:0] score;
  logic [9:0]  label;
  logic        frame_end;

  modport source (output valid, left, top, right, bottom, score, label, frame_end,
                  input ready);
  modport sink (input valid, left, top, right, bottom, score, label, frame_end,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cnms_res_if.sv
// ----------------------------------------------------------------------------
// cnms_res_if: kept box output channel
// Valid/ready channel carrying one kept detection per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cnms_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_left;
  logic [15:0] kept_top;
  logic [15:0] kept_right;
  logic [15:0] kept_bottom;
  logic [15:0] kept_score;
  logic [9:0]  kept_class;
  logic        none_kept;
  logic        overflowed;
  logic        run_last;

  modport source (output valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                  kept_class, none_kept, overflowed, run_last, input ready);
  modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                kept_class, none_kept, overflowed, run_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cnms_ram.sv
// ----------------------------------------------------------------------------
// cnms_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cnms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/containment_nms_per_class.sv
// ----------------------------------------------------------------------------
// containment_nms_per_class: per-class greedy containment suppression
// Area-sorted detection store with a sequenced suppression pass at frame end.
// ----------------------------------------------------------------------------
// Detections arrive one per beat on det. Each is inserted into an area-sorted
// store (equal areas keep arrival order); insertion walks the store from the
// top, shifting up each stored entry whose area is larger than the new one.
// det.ready is low during insertion and during the suppression pass.
// The beat with frame_end starts the pass: each unsuppressed entry is kept
// and compared against every later entry: entries that are suppressed or of
// another class are skipped and same-class pairs are tested, all through one
// shared 32x16 multiplier and the single read port of the store RAM. Kept
// boxes leave on res in area order, the final one with run_last. A kept box
// is held one step behind so that run_last can be marked; the pass waits at
// each kept box and at the finish while res is stalled.
// Configuration (cfg_we/cfg_wdata) sets the threshold; the user must write
// it only while idle, which the block does not enforce. Synchronous reset
// empties the store and restores the 0.3 threshold; store contents are not
// cleared, only the count. Detections past MAX_DETS are dropped and flagged
// through overflowed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module containment_nms_per_class
  import cnms_pkg::*;
#(
  parameter int unsigned MAX_DETS   = MaxDetsDefault,
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  cnms_det_if.sink         det,
  cnms_res_if.source       res,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  localparam int unsigned IDX_W = $clog2(MAX_DETS);
  localparam int unsigned CNT_W = $clog2(MAX_DETS + 1);
  localparam logic [15:0] CMASK = (COORD_BITS >= 16) ? 16'hFFFF
                                                     : 16'((32'd1 << COORD_BITS) - 32'd1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_AREA = 12'b000000000010,
    S_SH   = 12'b000000000100,
    S_SHW  = 12'b000000001000,
    S_PI   = 12'b000000010000,
    S_PIW  = 12'b000000100000,
    S_KEEP = 12'b000001000000,
    S_PJ   = 12'b000010000000,
    S_PJW  = 12'b000100000000,
    S_M1   = 12'b001000000000,
    S_M2   = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state;

  logic [15:0]          thr;
  logic [CNT_W-1:0]     count, pos, i, j;
  logic                 ovf;
  logic                 fe;
  cnms_entry_t          nw, ref_e, pend;
  logic                 pend_v;
  logic [15:0]          sx, sy;
  logic [31:0]          amin, inter;

  // Store RAM.
  logic                 we, re;
  logic [IDX_W-1:0]     waddr, raddr;
  cnms_entry_t          wdata, rdata;

  cnms_ram #(.WIDTH($bits(cnms_entry_t)), .DEPTH(MAX_DETS)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  always_comb begin
    mul_a = {16'd0, sx};
    mul_b = sy;
    if (state == S_M2) begin
      mul_a = amin;
      mul_b = thr;
    end
  end

  // Containment test: inter / min_area > thr, cross-multiplied.
  logic hit;
  assign hit = ({inter, 16'd0} > mul_p);

  logic [CNT_W-1:0] pos_m1;
  assign pos_m1 = pos - 1'b1;

  logic out_free;
  assign out_free = !res.valid || res.ready;

  logic res_load;
  assign res_load = ((state == S_KEEP) && pend_v && out_free) ||
                    ((state == S_FIN) && out_free);

  assign det.ready = (state == S_IDLE);

  // Intersection of the reference box and the entry just read.
  logic [15:0] il, it, ir, ib;
  always_comb begin
    il = (ref_e.left   > rdata.left)   ? ref_e.left   : rdata.left;
    it = (ref_e.top    > rdata.top)    ? ref_e.top    : rdata.top;
    ir = (ref_e.right  < rdata.right)  ? ref_e.right  : rdata.right;
    ib = (ref_e.bottom < rdata.bottom) ? ref_e.bottom : rdata.bottom;
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos[IDX_W-1:0];
    wdata = nw;
    re    = 1'b0;
    raddr = pos_m1[IDX_W-1:0];
    unique case (state)
      S_SH: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          re = 1'b1;
        end
      end
      S_SHW: begin
        we = 1'b1;
        if (rdata.area > nw.area) begin
          wdata = rdata;
        end
      end
      S_PI: begin
        re    = 1'b1;
        raddr = i[IDX_W-1:0];
      end
      S_PJ: begin
        re    = 1'b1;
        raddr = j[IDX_W-1:0];
      end
      S_M2: begin
        // The read data still holds entry j; write it back marked.
        we        = hit;
        waddr     = j[IDX_W-1:0];
        wdata     = rdata;
        wdata.sup = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      thr       <= ThresholdReset;
      count     <= '0;
      ovf       <= 1'b0;
      pend_v    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (det.valid) begin
            nw.left   <= det.left & CMASK;
            nw.top    <= det.top & CMASK;
            nw.right  <= det.right & CMASK;
            nw.bottom <= det.bottom & CMASK;
            nw.score  <= det.score;
            nw.cls    <= det.label;
            nw.sup    <= 1'b0;
            sx        <= span16(det.left & CMASK, det.right & CMASK);
            sy        <= span16(det.top & CMASK, det.bottom & CMASK);
            fe        <= det.frame_end;
            state     <= S_AREA;
          end
        end
        S_AREA: begin
          nw.area <= mul_p[31:0];
          pos     <= count;
          if (count >= CNT_W'(MAX_DETS)) begin
            ovf <= 1'b1;
            i   <= '0;
            state <= fe ? S_PI : S_IDLE;
          end else begin
            state <= S_SH;
          end
        end
        S_SH: begin
          if (pos == '0) begin
            count <= count + 1'b1;
            i     <= '0;
            state <= fe ? S_PI : S_IDLE;
          end else begin
            state <= S_SHW;
          end
        end
        S_SHW: begin
          if (rdata.area > nw.area) begin
            pos   <= pos_m1;
            state <= S_SH;
          end else begin
            count <= count + 1'b1;
            i     <= '0;
            state <= fe ? S_PI : S_IDLE;
          end
        end
        S_PI: begin
          if (i == count) begin
            state <= S_FIN;
          end else begin
            state <= S_PIW;
          end
        end
        S_PIW: begin
          if (rdata.sup) begin
            i     <= i + 1'b1;
            state <= S_PI;
          end else begin
            ref_e <= rdata;
            state <= S_KEEP;
          end
        end
        S_KEEP: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              res.kept_left   <= pend.left;
              res.kept_top    <= pend.top;
              res.kept_right  <= pend.right;
              res.kept_bottom <= pend.bottom;
              res.kept_score  <= pend.score;
              res.kept_class  <= pend.cls;
              res.none_kept   <= 1'b0;
              res.overflowed  <= ovf;
              res.run_last    <= 1'b0;
            end
            pend   <= ref_e;
            pend_v <= 1'b1;
            j      <= i + 1'b1;
            state  <= S_PJ;
          end
        end
        S_PJ: begin
          if (j == count) begin
            i     <= i + 1'b1;
            state <= S_PI;
          end else begin
            state <= S_PJW;
          end
        end
        S_PJW: begin
          if (rdata.sup || (rdata.cls != ref_e.cls)) begin
            j     <= j + 1'b1;
            state <= S_PJ;
          end else begin
            sx    <= span16(il, ir);
            sy    <= span16(it, ib);
            amin  <= (ref_e.area < rdata.area) ? ref_e.area : rdata.area;
            state <= S_M1;
          end
        end
        S_M1: begin
          inter <= mul_p[31:0];
          state <= S_M2;
        end
        S_M2: begin
          j     <= j + 1'b1;
          state <= S_PJ;
        end
        S_FIN: begin
          if (out_free) begin
            res.kept_left   <= pend_v ? pend.left : 16'd0;
            res.kept_top    <= pend_v ? pend.top : 16'd0;
            res.kept_right  <= pend_v ? pend.right : 16'd0;
            res.kept_bottom <= pend_v ? pend.bottom : 16'd0;
            res.kept_score  <= pend_v ? pend.score : 16'd0;
            res.kept_class  <= pend_v ? pend.cls : 10'd0;
            res.none_kept   <= !pend_v;
            res.overflowed  <= ovf;
            res.run_last    <= 1'b1;
            pend_v <= 1'b0;
            count  <= '0;
            ovf    <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: tb/containment_nms_per_class_tb.sv
// ----------------------------------------------------------------------------
// containment_nms_per_class_tb: self-checking bench for containment NMS
// Drives frames of detections, predicts kept boxes per class, and compares
// every kept-box beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module containment_nms_per_class_tb;
  import cnms_pkg::*;

  localparam int unsigned DetCap = 64;
  localparam int unsigned WatchLimit = 200000;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
    logic [9:0]  cls;
    logic        frame_end;
  } det_beat_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
    logic [9:0]  cls;
    logic        none_kept;
    logic        overflowed;
    logic        run_last;
  } kept_box_t;

  localparam logic [15:0] Thresholds [5] = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd19661};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  cnms_det_if det ();
  cnms_res_if res ();

  containment_nms_per_class dut (
    .clk       (clk),
    .rst       (rst),
    .det       (det),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the area-sorted store of the current frame.
  det_beat_t   frame_boxes[$];
  logic [31:0] frame_areas[$];
  logic        frame_overflow = 1'b0;
  logic [15:0] threshold = ThresholdReset;
  kept_box_t   kept_queue[$];

  int errors = 0;
  int idle_send = 0;
  int idle_recv = 0;
  int watch = 0;

  function automatic logic [31:0] box_area(input det_beat_t d);
    return 32'(span16(d.left, d.right)) * 32'(span16(d.top, d.bottom));
  endfunction

  task automatic report_mismatch(input string what, input kept_box_t got,
                                 input kept_box_t want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Adds one detection to the frame and, on frame end, predicts the kept boxes.
  task automatic predict_detection(input det_beat_t d);
    int pos;
    logic [31:0] a;
    logic        sup[$];
    logic [15:0] l, t, r, b;
    logic [31:0] inter, amin;
    logic [47:0] lhs, rhs;
    kept_box_t k;
    int n;
    a = box_area(d);
    if (frame_boxes.size() >= DetCap) begin
      frame_overflow = 1'b1;
    end else begin
      pos = frame_boxes.size();
      while (pos > 0 && frame_areas[pos-1] > a) pos--;
      frame_boxes.insert(pos, d);
      frame_areas.insert(pos, a);
    end
    if (!d.frame_end) return;
    n = 0;
    foreach (frame_boxes[i]) sup.insert(sup.size(), 1'b0);
    for (int i = 0; i < frame_boxes.size(); i++) begin
      if (sup[i]) continue;
      k = '{frame_boxes[i].left, frame_boxes[i].top, frame_boxes[i].right,
            frame_boxes[i].bottom, frame_boxes[i].score, frame_boxes[i].cls,
            1'b0, frame_overflow, 1'b0};
      kept_queue.insert(kept_queue.size(), k);
      n++;
      for (int j = i + 1; j < frame_boxes.size(); j++) begin
        if (sup[j] || frame_boxes[i].cls != frame_boxes[j].cls) continue;
        amin = frame_areas[i] < frame_areas[j] ? frame_areas[i] : frame_areas[j];
        l = frame_boxes[i].left > frame_boxes[j].left ? frame_boxes[i].left
                                                      : frame_boxes[j].left;
        t = frame_boxes[i].top > frame_boxes[j].top ? frame_boxes[i].top
                                                    : frame_boxes[j].top;
        r = frame_boxes[i].right < frame_boxes[j].right ? frame_boxes[i].right
                                                        : frame_boxes[j].right;
        b = frame_boxes[i].bottom < frame_boxes[j].bottom ? frame_boxes[i].bottom
                                                          : frame_boxes[j].bottom;
        inter = 32'(span16(l, r)) * 32'(span16(t, b));
        lhs = {inter, 16'd0};
        rhs = 48'(threshold) * 48'(amin);
        if (lhs > rhs) sup[j] = 1'b1;
      end
    end
    if (n == 0) begin
      k = '0;
      k.none_kept = 1'b1;
      k.overflowed = frame_overflow;
      kept_queue.insert(kept_queue.size(), k);
    end
    kept_queue[kept_queue.size()-1].run_last = 1'b1;
    frame_boxes.delete();
    frame_areas.delete();
    frame_overflow = 1'b0;
  endtask

  // Result side: random stall, compare each accepted beat.
  always @(posedge clk) begin
    kept_box_t want;
    kept_box_t got;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= idle_recv);
      if (res.valid && res.ready) begin
        got = '{res.kept_left, res.kept_top, res.kept_right, res.kept_bottom,
                res.kept_score, res.kept_class, res.none_kept, res.overflowed,
                res.run_last};
        if (kept_queue.size() == 0) begin
          report_mismatch("unexpected kept box", got, '0);
        end else begin
          want = kept_queue.pop_front();
          if (got !== want) report_mismatch("kept box", got, want);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((det.valid && det.ready) || (res.valid && res.ready)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("[containment_nms_per_class] ERROR");
      $finish;
    end
  end

  // Sends one detection, holding valid until the beat is accepted. Valid is
  // left high after the accepting edge; the next call or a drain drops it.
  task automatic send_detection(input det_beat_t d);
    while ($urandom_range(99) < idle_send) begin
      det.valid <= 1'b0;
      @(posedge clk);
    end
    det.valid <= 1'b1;
    det.left <= d.left;
    det.top <= d.top;
    det.right <= d.right;
    det.bottom <= d.bottom;
    det.score <= d.score;
    det.label <= d.cls;
    det.frame_end <= d.frame_end;
    @(posedge clk);
    while (!det.ready) @(posedge clk);
    predict_detection(d);
  endtask

  task automatic drain_results();
    det.valid <= 1'b0;
    while (kept_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic det_beat_t random_box(input int cls_span, input logic fe);
    det_beat_t d;
    logic [15:0] x, y;
    d.score = 16'($urandom);
    d.cls = (cls_span == 0) ? 10'($urandom) : 10'($urandom_range(cls_span));
    d.frame_end = fe;
    if ($urandom_range(9) == 0) begin
      // Fully random corners, reversed extents included.
      d.left = 16'($urandom);
      d.top = 16'($urandom);
      d.right = 16'($urandom);
      d.bottom = 16'($urandom);
    end else begin
      x = 16'($urandom_range(60000));
      y = 16'($urandom_range(60000));
      d.left = x;
      d.top = y;
      d.right = 16'(32'(x) + $urandom_range(5535));
      d.bottom = 16'(32'(y) + $urandom_range(5535));
    end
    return d;
  endfunction

  // Directed rows; the first frames have results that are obvious by eye.
  det_beat_t directed_rows[10] = '{
    '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 1'b1},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 10'h000, 1'b1},
    '{16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h1234, 10'h005, 1'b0},
    '{16'h0000, 16'h0000, 16'h0200, 16'h0200, 16'h2345, 10'h005, 1'b0},
    '{16'h0080, 16'h0080, 16'h0180, 16'h0180, 16'h3456, 10'h006, 1'b0},
    '{16'h0200, 16'h0000, 16'h0100, 16'h0100, 16'h4567, 10'h005, 1'b0},
    '{16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h5678, 10'h005, 1'b1},
    '{16'h1000, 16'h1000, 16'h2000, 16'h2000, 16'hAAAA, 10'h2AA, 1'b0},
    '{16'h1800, 16'h1800, 16'h2800, 16'h2800, 16'h5555, 10'h2AA, 1'b0},
    '{16'h1C00, 16'h1C00, 16'h2C00, 16'h2C00, 16'h0001, 10'h155, 1'b1}
  };

  kept_box_t obvious_first = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF,
                               1'b0, 1'b0, 1'b1};

  initial begin
    int frame_len;
    det.valid = 1'b0;
    det.left = '0;
    det.top = '0;
    det.right = '0;
    det.bottom = '0;
    det.score = '0;
    det.label = '0;
    det.frame_end = 1'b0;
    res.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_detection(directed_rows[i]);
      // A whole-range box alone in its frame comes straight back.
      if (i == 0 && kept_queue[0] !== obvious_first)
        report_mismatch("first frame prediction", kept_queue[0], obvious_first);
    end
    drain_results();
    // Overflow frame: one beat past capacity, and that extra beat, which carries the frame end, is dropped.
    for (int i = 0; i <= DetCap; i++) send_detection(random_box(3, i == DetCap));
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      idle_send = (phase == 0) ? 34 : (phase == 1) ? 88 : 0;
      idle_recv = (phase == 0) ? 88 : (phase == 1) ? 34 : 0;
      for (int s = 0; s < 5; s++) begin
        write_threshold(Thresholds[(s + phase) % 5]);
        for (int f = 0; f < 3; f++) begin
          frame_len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 40))
                                               : int'($urandom_range(1, 12));
          for (int i = 0; i < frame_len; i++)
            send_detection(random_box((f == 2) ? 0 : 2, i == frame_len - 1));
        end
        drain_results();
      end
    end
    idle_recv = 0;
    drain_results();
    if (errors == 0) begin
      $display("[containment_nms_per_class] OK");
    end else begin
      $display("[containment_nms_per_class] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
